// File: src/isb_pkg.sv
// Package for the indexed sequence store: sizes, command and status codes,
// and the control struct that steers each storage cell. No dependencies.
package isb_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FPOS_W = 4;
  localparam int unsigned CNTO_W = 5;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

// File: src/indexed_sequence_store.sv
// Indexed sequence store: an ordered list of DEPTH elements kept in a chain
// of cells that shift toward the tail on insert and toward the head on delete.
//
// A command is taken at a rising edge where start is high and busy is low.
// Its fields are cmd_i, position_i and value_i. Every command gives exactly
// one result, shown on the result ports for one cycle while done_o is high.
// The result appears in the cycle right after the command is taken, as all
// cells shift or compare in parallel in the cycle the command is taken, and
// the search priority encoder and the read multiplexer feed the result
// registers directly. busy is always low, so a command may be issued every
// cycle.
// count_o gives the number of elements after the command, status_o reports
// an out-of-range position or a full store, in which case nothing changes.
// Reset clears the element count and drops any pending result; element
// contents are not cleared and are never visible before being written.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Depends on isb_pkg and isb_cell.
module indexed_sequence_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [isb_pkg::CMD_W-1:0]  cmd_i,
  input  logic [isb_pkg::POS_W-1:0]  position_i,
  input  logic [isb_pkg::VAL_W-1:0]  value_i,
  output logic                       done_o,
  output logic [isb_pkg::VAL_W-1:0]  read_value_o,
  output logic                       found_o,
  output logic [isb_pkg::FPOS_W-1:0] found_position_o,
  output logic [isb_pkg::CNTO_W-1:0] count_o,
  output logic [1:0]                 status_o
);
  import isb_pkg::*;

  logic                accept;
  logic [DATA_W-1:0]   key;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                full;
  logic                do_insert;
  logic                do_delete;
  logic [CMP_W-1:0]    ins_pos;

  logic [DATA_W-1:0]   cell_data  [DEPTH];
  logic [DEPTH-1:0]    cell_match;
  cell_ctrl_t          cell_ctrl  [DEPTH];

  logic [CNT_W-1:0]    count_q, count_d;
  logic                done_q;
  logic [VAL_W-1:0]    read_value_q, read_value_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    fpos_q, fpos_d;
  status_e             status_q, status_d;

  assign accept  = start && !busy;
  assign busy    = 1'b0;
  assign key     = DATA_W'(value_i);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q >= CNT_W'(DEPTH));

  always_comb begin
    do_insert    = 1'b0;
    do_delete    = 1'b0;
    ins_pos      = pos_ext;
    count_d      = count_q;
    read_value_d = '0;
    found_d      = 1'b0;
    fpos_d       = '0;
    status_d     = ST_OK;
    case (cmd_e'(cmd_i))
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      CMD_APPEND: begin
        ins_pos = cnt_ext;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          do_delete = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          read_value_d = VAL_W'(cell_data[pos_ext[IDX_W-1:0]]);
        end
      end
      CMD_SEARCH: begin
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (cell_match[i] && (CMP_W'(i) < cnt_ext)) begin
            found_d = 1'b1;
            fpos_d  = IDX_W'(i);
          end
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_delete) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].value = key;
      cell_ctrl[i].op    = CELL_HOLD;
      if (accept && do_insert) begin
        if (CMP_W'(i) == ins_pos) begin
          cell_ctrl[i].op = CELL_LOAD;
        end else if (CMP_W'(i) > ins_pos) begin
          cell_ctrl[i].op = CELL_TAKE_LEFT;
        end
      end else if (accept && do_delete) begin
        if (CMP_W'(i) >= pos_ext) begin
          cell_ctrl[i].op = CELL_TAKE_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (g == 0) begin : g_head
      assign left_data = key;
    end else begin : g_body
      assign left_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[g];
    end else begin : g_inner
      assign right_data = cell_data[g+1];
    end
    isb_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      found_q      <= found_d;
      fpos_q       <= fpos_d;
      status_q     <= status_d;
    end
  end

  assign done_o           = done_q;
  assign read_value_o     = read_value_q;
  assign found_o          = found_q;
  assign found_position_o = FPOS_W'(fpos_q);
  assign count_o          = CNTO_W'(count_q);
  assign status_o         = status_q;

endmodule

// File: src/isb_cell.sv
// One storage cell of the chain: holds one element, loads a new value or
// takes its neighbor's element, and compares its element with the key.
// Depends on isb_pkg.
module isb_cell (
  input  logic                       clk_i,
  input  isb_pkg::cell_ctrl_t        ctrl_i,
  input  logic [isb_pkg::DATA_W-1:0] left_i,
  input  logic [isb_pkg::DATA_W-1:0] right_i,
  output logic [isb_pkg::DATA_W-1:0] data_o,
  output logic                       match_o
);
  import isb_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD:       data_d = ctrl_i.value;
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == ctrl_i.value);

endmodule

// File: src/isb_checker.sv
// Port-level checker for the indexed sequence store, bound to the top level.
// Depends on isb_pkg and indexed_sequence_store.
module isb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [isb_pkg::VAL_W-1:0]  read_value_o,
  input logic                       found_o,
  input logic [isb_pkg::FPOS_W-1:0] found_position_o,
  input logic [isb_pkg::CNTO_W-1:0] count_o,
  input logic [1:0]                 status_o
);
  import isb_pkg::*;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o) else $error("command gave no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o) else $error("result without a command");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_o <= CNTO_W'(DEPTH))) else $error("count above capacity");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> ((read_value_o == '0) && !found_o))
    else $error("failed command returned data");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (CNTO_W'(found_position_o) < count_o))
    else $error("found position beyond count");

endmodule

bind indexed_sequence_store isb_checker u_isb_checker (.*);
